/* sv/assert_macros.svh */
// assertion macros shared by the slerp rtl
// depends on nothing; included by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/qslerp_pkg.sv */
// shared constants, cell state types and the cordic angle table for the slerp unit
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package qslerp_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int ONE_Q        = 16384;
    localparam int SQRT_STEPS   = 15;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 29;

    localparam logic [28:0] SQ_TOP   = 29'd268435456;
    localparam logic [33:0] CORDIC_K = 34'd652032874;

    // pipeline positions of the sideband delay line
    localparam int ST_SQRT0 = 3;
    localparam int ST_VEC0  = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_TH    = ST_VEC0 + CORDIC_STEPS;
    localparam int ST_ROT0  = ST_TH + 1;
    localparam int ST_MAG   = ST_ROT0 + CORDIC_STEPS;
    localparam int ST_DIV0  = ST_MAG + 1;
    localparam int ST_PROD  = ST_DIV0 + DIV_STEPS;

    typedef struct packed {
        logic [28:0] rem;
        logic [29:0] res;
    } t_sqrt;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } t_cordic;

    typedef struct packed {
        logic [28:0] num;
        logic [14:0] rem;
        logic [28:0] quo;
    } t_div;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] b;
        logic [13:0]      t;
        logic             pass;
        logic             pass_b;
        logic             linear;
        logic [14:0]      c;
        logic [14:0]      s;
    } t_side;

    // atan(2^-i) in q30 radians
    function automatic logic [32:0] atan_q30(input logic [4:0] i);
        logic [32:0] v;
        unique case (i)
            5'd0:    v = 33'd843314857;
            5'd1:    v = 33'd497837830;
            5'd2:    v = 33'd263043837;
            5'd3:    v = 33'd133525159;
            5'd4:    v = 33'd67021687;
            5'd5:    v = 33'd33543516;
            5'd6:    v = 33'd16775851;
            5'd7:    v = 33'd8388437;
            5'd8:    v = 33'd4194283;
            5'd9:    v = 33'd2097149;
            5'd10:   v = 33'd1048576;
            5'd11:   v = 33'd524288;
            5'd12:   v = 33'd262144;
            5'd13:   v = 33'd131072;
            5'd14:   v = 33'd65536;
            5'd15:   v = 33'd32768;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/qslerp_sqrt_cell.sv */
// one digit of the integer square root: a registered step of the root chain
// depends on qslerp_pkg
`timescale 1ns / 1ps
`default_nettype none

module qslerp_sqrt_cell import qslerp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [3:0] i_step,
    input  wire t_sqrt      i_d,
    output t_sqrt           o_q
);

    logic [29:0] w_bit;
    logic [29:0] w_trial;
    t_sqrt       n_q;
    t_sqrt       r_q;

    // trial bit walks down by powers of four
    assign w_bit   = 30'(1) << (5'd28 - {i_step, 1'b0});
    assign w_trial = i_d.res + w_bit;

    always_comb begin
        n_q = i_d;
        if ({1'b0, i_d.rem} >= w_trial) begin
            n_q.rem = 29'({1'b0, i_d.rem} - w_trial);
            n_q.res = (i_d.res >> 1) + w_bit;
        end else begin
            n_q.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

/* sv/qslerp_vec_cell.sv */
// one vectoring cordic iteration, drives y toward zero and sums the angle
// depends on qslerp_pkg
`timescale 1ns / 1ps
`default_nettype none

module qslerp_vec_cell import qslerp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [4:0] i_step,
    input  wire t_cordic    i_d,
    output t_cordic         o_q
);

    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [32:0] w_ang;
    t_cordic            n_q;
    t_cordic            r_q;

    assign w_dx  = $signed(i_d.y) >>> i_step;
    assign w_dy  = $signed(i_d.x) >>> i_step;
    assign w_ang = $signed(atan_q30(i_step));

    always_comb begin
        n_q = i_d;
        if (!i_d.y[33]) begin
            n_q.x = i_d.x + w_dx;
            n_q.y = i_d.y - w_dy;
            n_q.z = i_d.z + w_ang;
        end else begin
            n_q.x = i_d.x - w_dx;
            n_q.y = i_d.y + w_dy;
            n_q.z = i_d.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

/* sv/qslerp_rot_cell.sv */
// one rotation cordic iteration, drives the residual angle toward zero
// depends on qslerp_pkg
`timescale 1ns / 1ps
`default_nettype none

module qslerp_rot_cell import qslerp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [4:0] i_step,
    input  wire t_cordic    i_d,
    output t_cordic         o_q
);

    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [32:0] w_ang;
    t_cordic            n_q;
    t_cordic            r_q;

    assign w_dx  = $signed(i_d.y) >>> i_step;
    assign w_dy  = $signed(i_d.x) >>> i_step;
    assign w_ang = $signed(atan_q30(i_step));

    always_comb begin
        n_q = i_d;
        if (!i_d.z[32]) begin
            n_q.x = i_d.x - w_dx;
            n_q.y = i_d.y + w_dy;
            n_q.z = i_d.z - w_ang;
        end else begin
            n_q.x = i_d.x + w_dx;
            n_q.y = i_d.y - w_dy;
            n_q.z = i_d.z + w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

/* sv/qslerp_div_cell.sv */
// one restoring division step: one quotient bit per cell, msb first
// depends on qslerp_pkg
`timescale 1ns / 1ps
`default_nettype none

module qslerp_div_cell import qslerp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [14:0] i_div,
    input  wire t_div        i_d,
    output t_div             o_q
);

    logic [15:0] w_rem2;
    logic        w_ge;
    t_div        n_q;
    t_div        r_q;

    assign w_rem2 = {i_d.rem, i_d.num[28]};
    assign w_ge   = w_rem2 >= {1'b0, i_div};

    always_comb begin
        n_q.num = {i_d.num[27:0], 1'b0};
        n_q.rem = w_ge ? 15'(w_rem2 - {1'b0, i_div}) : w_rem2[14:0];
        n_q.quo = {i_d.quo[27:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

/* sv/quaternion_slerp_unit.sv */
// top level of the fixed-point quaternion slerp pipeline
// depends on qslerp_pkg, the four cell modules and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Fully pipelined slerp: one quaternion pair is accepted every clock while the
// output side does not stall. Each result passes through a row of 83 register
// stages, the first of which loads at the edge that accepts its input beat: dot
// product and clamp (3), square root (15 cells), vectoring cordic for the angle
// (16), angle scaling (1), two sine cordic rows in parallel (16), magnitude (1),
// two divider rows in parallel (29), weighting (1) and the rounded output
// register (1). The whole pipe advances together; it holds only while a finished
// result waits on the output side, so o_ready is low exactly when o_valid is high
// and i_ready is low. cos_threshold may be written only while the pipe is empty.
module quaternion_slerp_unit import qslerp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [14:0] i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_a_w,
    input  wire logic signed [15:0] i_a_x,
    input  wire logic signed [15:0] i_a_y,
    input  wire logic signed [15:0] i_a_z,
    input  wire logic signed [15:0] i_b_w,
    input  wire logic signed [15:0] i_b_x,
    input  wire logic signed [15:0] i_b_y,
    input  wire logic signed [15:0] i_b_z,
    input  wire logic signed [15:0] i_fraction,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_r_w,
    output logic signed [15:0]      o_r_x,
    output logic signed [15:0]      o_r_y,
    output logic signed [15:0]      o_r_z
);

    logic               w_en;
    logic [14:0]        r_thr;
    logic [ST_PROD:0]   r_vld;
    t_side              r_side [ST_PROD+1];
    t_side              n_side [ST_PROD+1];

    logic signed [15:0] w_a [4];
    logic signed [15:0] w_b [4];

    logic signed [31:0] r_prod [4];
    logic signed [33:0] w_dot;
    logic               w_dot_neg;
    logic [32:0]        r_absdot;
    logic [18:0]        w_cq;
    logic [14:0]        w_c;
    logic [28:0]        r_csq;

    t_sqrt              w_sqrt_d [SQRT_STEPS];
    t_sqrt              w_sqrt_q [SQRT_STEPS];
    t_cordic            w_vec_d  [CORDIC_STEPS];
    t_cordic            w_vec_q  [CORDIC_STEPS];

    logic [14:0]        w_w0;
    logic signed [48:0] w_thp0;
    logic signed [48:0] w_thp1;
    logic signed [32:0] r_th0;
    logic signed [32:0] r_th1;

    t_cordic            w_rot0_d [CORDIC_STEPS];
    t_cordic            w_rot0_q [CORDIC_STEPS];
    t_cordic            w_rot1_d [CORDIC_STEPS];
    t_cordic            w_rot1_q [CORDIC_STEPS];

    logic signed [33:0] w_sin0;
    logic signed [33:0] w_sin1;
    logic [33:0]        w_abs0;
    logic [33:0]        w_abs1;
    logic [28:0]        r_mag0;
    logic [28:0]        r_mag1;
    logic               r_neg0 [DIV_STEPS+1];
    logic               r_neg1 [DIV_STEPS+1];

    t_div               w_div0_d [DIV_STEPS];
    t_div               w_div0_q [DIV_STEPS];
    t_div               w_div1_d [DIV_STEPS];
    t_div               w_div1_q [DIV_STEPS];

    logic               w_lin;
    logic signed [29:0] w_k0;
    logic signed [29:0] w_k1;
    logic signed [46:0] r_pa [4];
    logic signed [46:0] r_pb [4];

    logic signed [47:0] w_sum [4];
    logic signed [15:0] w_res [4];
    logic               r_out_vld;
    logic signed [15:0] r_r [4];

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    assign w_a[0] = i_a_w;
    assign w_a[1] = i_a_x;
    assign w_a[2] = i_a_y;
    assign w_a[3] = i_a_z;
    assign w_b[0] = i_b_w;
    assign w_b[1] = i_b_x;
    assign w_b[2] = i_b_y;
    assign w_b[3] = i_b_z;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= 15'd16382;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_en) begin
                r_vld     <= {r_vld[ST_PROD-1:0], i_valid};
                r_out_vld <= r_vld[ST_PROD];
            end
        end
    end

    // dot product, clamp and sideband updates
    always_comb begin
        w_dot = 34'(r_prod[0]) + 34'(r_prod[1]) + 34'(r_prod[2]) + 34'(r_prod[3]);
        w_dot_neg = w_dot[33];
        w_cq = r_absdot[32:14];
        w_c  = (w_cq > 19'(ONE_Q)) ? 15'(ONE_Q) : w_cq[14:0];

        for (int i = 0; i < 4; i++) begin
            n_side[0].a[i] = w_a[i];
            n_side[0].b[i] = {w_b[i][15], w_b[i]};
        end
        n_side[0].t      = i_fraction[13:0];
        n_side[0].pass   = (i_fraction <= 16'sd0) || (i_fraction >= 16'sd16384);
        n_side[0].pass_b = !(i_fraction <= 16'sd0);
        n_side[0].linear = 1'b0;
        n_side[0].c      = '0;
        n_side[0].s      = '0;

        for (int j = 1; j <= ST_PROD; j++) begin
            n_side[j] = r_side[j-1];
        end
        // pass-through beats keep b as it came in
        for (int i = 0; i < 4; i++) begin
            if (w_dot_neg && !r_side[0].pass) begin
                n_side[1].b[i] = 17'(-$signed(r_side[0].b[i]));
            end
        end
        n_side[2].linear = w_cq > 19'(r_thr);
        n_side[2].c      = w_c;
        n_side[ST_VEC0].s = w_sqrt_q[SQRT_STEPS-1].res[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side <= n_side;
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= w_a[i] * w_b[i];
            end
            r_absdot <= w_dot_neg ? 33'(-w_dot) : w_dot[32:0];
            r_csq    <= 29'(w_c) * 29'(w_c);
        end
    end

    // square root row: sine of the angle as sqrt(1 - c^2)
    always_comb begin
        w_sqrt_d[0].rem = SQ_TOP - r_csq;
        w_sqrt_d[0].res = '0;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            w_sqrt_d[k] = w_sqrt_q[k-1];
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        qslerp_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (4'(k)),
            .i_d    (w_sqrt_d[k]),
            .o_q    (w_sqrt_q[k])
        );
    end

    // angle row: atan2(s, c) in q30
    always_comb begin
        w_vec_d[0].x = 34'({r_side[ST_VEC0-1].c, 16'b0});
        w_vec_d[0].y = 34'({w_sqrt_q[SQRT_STEPS-1].res[14:0], 16'b0});
        w_vec_d[0].z = '0;
        for (int k = 1; k < CORDIC_STEPS; k++) begin
            w_vec_d[k] = w_vec_q[k-1];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        qslerp_vec_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (5'(k)),
            .i_d    (w_vec_d[k]),
            .o_q    (w_vec_q[k])
        );
    end

    // scale the angle by (1-t) and t
    assign w_w0   = 15'(ONE_Q) - {1'b0, r_side[ST_TH-1].t};
    assign w_thp0 = $signed({1'b0, w_w0}) * $signed(w_vec_q[CORDIC_STEPS-1].z);
    assign w_thp1 = $signed({2'b0, r_side[ST_TH-1].t}) * $signed(w_vec_q[CORDIC_STEPS-1].z);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_th0 <= w_thp0[46:14];
            r_th1 <= w_thp1[46:14];
        end
    end

    // two sine rows in parallel
    always_comb begin
        w_rot0_d[0].x = CORDIC_K;
        w_rot0_d[0].y = '0;
        w_rot0_d[0].z = r_th0;
        w_rot1_d[0].x = CORDIC_K;
        w_rot1_d[0].y = '0;
        w_rot1_d[0].z = r_th1;
        for (int k = 1; k < CORDIC_STEPS; k++) begin
            w_rot0_d[k] = w_rot0_q[k-1];
            w_rot1_d[k] = w_rot1_q[k-1];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        qslerp_rot_cell u_cell0 (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (5'(k)),
            .i_d    (w_rot0_d[k]),
            .o_q    (w_rot0_q[k])
        );
        qslerp_rot_cell u_cell1 (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (5'(k)),
            .i_d    (w_rot1_d[k]),
            .o_q    (w_rot1_q[k])
        );
    end

    // sin * ONE / (s << 16) truncates toward zero, i.e. |sin| / 4 / s with sign
    assign w_sin0 = w_rot0_q[CORDIC_STEPS-1].y;
    assign w_sin1 = w_rot1_q[CORDIC_STEPS-1].y;
    assign w_abs0 = w_sin0[33] ? 34'(-w_sin0) : w_sin0;
    assign w_abs1 = w_sin1[33] ? 34'(-w_sin1) : w_sin1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag0    <= w_abs0[30:2];
            r_mag1    <= w_abs1[30:2];
            r_neg0[0] <= w_sin0[33];
            r_neg1[0] <= w_sin1[33];
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_neg0[k] <= r_neg0[k-1];
                r_neg1[k] <= r_neg1[k-1];
            end
        end
    end

    always_comb begin
        w_div0_d[0].num = r_mag0;
        w_div0_d[0].rem = '0;
        w_div0_d[0].quo = '0;
        w_div1_d[0].num = r_mag1;
        w_div1_d[0].rem = '0;
        w_div1_d[0].quo = '0;
        for (int k = 1; k < DIV_STEPS; k++) begin
            w_div0_d[k] = w_div0_q[k-1];
            w_div1_d[k] = w_div1_q[k-1];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        qslerp_div_cell u_cell0 (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_div  (r_side[ST_MAG+k].s),
            .i_d    (w_div0_d[k]),
            .o_q    (w_div0_q[k])
        );
        qslerp_div_cell u_cell1 (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_div  (r_side[ST_MAG+k].s),
            .i_d    (w_div1_d[k]),
            .o_q    (w_div1_q[k])
        );
    end

    // weights: linear near parallel inputs or at zero sine
    always_comb begin
        w_lin = r_side[ST_PROD-1].linear || (r_side[ST_PROD-1].s == 15'd0);
        if (w_lin) begin
            w_k0 = 30'(ONE_Q) - 30'(r_side[ST_PROD-1].t);
            w_k1 = 30'(r_side[ST_PROD-1].t);
        end else begin
            w_k0 = r_neg0[DIV_STEPS] ? -$signed({1'b0, w_div0_q[DIV_STEPS-1].quo})
                                     : $signed({1'b0, w_div0_q[DIV_STEPS-1].quo});
            w_k1 = r_neg1[DIV_STEPS] ? -$signed({1'b0, w_div1_q[DIV_STEPS-1].quo})
                                     : $signed({1'b0, w_div1_q[DIV_STEPS-1].quo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_pa[i] <= w_k0 * $signed(r_side[ST_PROD-1].a[i]);
                r_pb[i] <= w_k1 * $signed(r_side[ST_PROD-1].b[i]);
            end
        end
    end

    // round half up, saturate, or pass an input through
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sum[i] = r_pa[i] + r_pb[i] + 48'sd8192;
            if (r_side[ST_PROD].pass) begin
                w_res[i] = r_side[ST_PROD].pass_b ? r_side[ST_PROD].b[i][15:0]
                                                  : r_side[ST_PROD].a[i];
            end else if ($signed(w_sum[i][47:14]) > 34'sd32767) begin
                w_res[i] = 16'sh7fff;
            end else if ($signed(w_sum[i][47:14]) < -34'sd32768) begin
                w_res[i] = 16'sh8000;
            end else begin
                w_res[i] = w_sum[i][29:14];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_r[i] <= w_res[i];
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_r_w   = r_r[0];
    assign o_r_x   = r_r[1];
    assign o_r_y   = r_r[2];
    assign o_r_z   = r_r[3];

    `ASSERT_NEXT(a_out_load, i_clk, i_rst_n, o_ready && r_vld[ST_PROD], o_valid, "result beat lost at output register")
    `ASSERT_IMPL(a_sqrt_zero, i_clk, i_rst_n, r_vld[ST_VEC0], (r_side[ST_VEC0].s == 15'd0) == (r_side[ST_VEC0].c == 15'(ONE_Q)), "sine is zero without unit cosine")
    `ASSERT_NEXT(a_pass_a, i_clk, i_rst_n, o_ready && r_vld[ST_PROD] && r_side[ST_PROD].pass && !r_side[ST_PROD].pass_b, o_r_w == $past(r_side[ST_PROD].a[0]), "pass-through of a corrupted")

endmodule

`default_nettype wire
